// ===== rtl/b64se_pkg.sv =====
// Shared types, constants and the sextet-to-ASCII mapping for the base64 stream encoder.
package b64se_pkg;

   localparam int BYTE_W       = 8;
   localparam int CHAR_W       = 7;
   localparam int SEXT_W       = 6;
   localparam int CARRY_W      = 4;
   localparam int MAX_CHARS    = 4;
   localparam int CIDX_W       = 2;
   localparam int QUEUE_DEPTH  = 2;

   localparam logic [CHAR_W-1:0] PAD_CHAR   = 7'd61;  // '='
   localparam logic [CHAR_W-1:0] UPPER_A    = 7'd65;  // 'A'
   localparam logic [CHAR_W-1:0] LOWER_OFS  = 7'd71;  // 'a' - 26
   localparam logic [CHAR_W-1:0] DIGIT_OFS  = 7'd4;   // 52 - '0'
   localparam logic [CHAR_W-1:0] PLUS_CHAR  = 7'd43;  // '+'
   localparam logic [CHAR_W-1:0] SLASH_CHAR = 7'd47;  // '/'

   // position within the three-byte group; the spare code behaves as the first
   typedef enum logic [1:0] {
      GRP_FIRST  = 2'd0,
      GRP_SECOND = 2'd1,
      GRP_THIRD  = 2'd2
   } grp_pos_type;

   // one encoded byte: up to four characters, index of the final one, end of message
   typedef struct packed {
      logic [MAX_CHARS-1:0][CHAR_W-1:0] chars;
      logic [CIDX_W-1:0]                last_idx;
      logic                             msg_last;
   } job_type;

   function automatic logic [CHAR_W-1:0] sextet_char(input logic [SEXT_W-1:0] s);
      logic [CHAR_W-1:0] s7;
      s7 = {1'b0, s};
      if (s < 6'd26)
         return UPPER_A + s7;
      else if (s < 6'd52)
         return LOWER_OFS + s7;
      else if (s < 6'd62)
         return s7 - DIGIT_OFS;
      else if (s == 6'd62)
         return PLUS_CHAR;
      else
         return SLASH_CHAR;
   endfunction

endpackage

// ===== rtl/b64se_if.sv =====
// Valid/ready channel interfaces for raw bytes in and base64 characters out.
interface b64se_req_if;
   import b64se_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;
   logic              last_byte;

   modport source (output valid, data_byte, last_byte, input ready);
   modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

interface b64se_rsp_if;
   import b64se_pkg::*;
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] char_code;
   logic              run_last;
   logic              message_end;

   modport source (output valid, char_code, run_last, message_end, input ready);
   modport sink   (input valid, char_code, run_last, message_end, output ready);
endinterface

// ===== rtl/base64_stream_encoder_core.sv =====
// A byte accepted on req is written into the job queue; the back end then registers its
//   first character for rsp.
// Throughput: one character per cycle out of the back end while rsp is ready; a byte
//   makes as many characters as its job holds (1, 1, 2 mid-message, up to 4 on a final byte).
// req_ch.ready follows only the job queue fill, not the output stall.
// Reset (synchronous, active high) empties the queue and output register and restarts the group.
module base64_stream_encoder_core #(
   parameter int QUEUE_DEPTH = b64se_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   b64se_req_if.sink   req_ch,
   b64se_rsp_if.source rsp_ch
);
   import b64se_pkg::*;

   // front -> queue
   logic    push;
   job_type push_job;
   logic    full;

   // queue -> back
   logic    head_valid;
   job_type head_job;
   logic    pop;

   // front end: one beat per byte, sextets mapped to ASCII here
   b64se_front u_front (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .full  (full),
      .push  (push),
      .job   (push_job)
   );

   // decouples byte intake from character output
   b64se_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .pop        (pop),
      .full       (full),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   // back end: serialises each job, one character beat per cycle while rsp is ready
   b64se_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop),
      .rsp        (rsp_ch)
   );

endmodule

// ===== rtl/b64se_front.sv =====
// Front end: takes byte beats, tracks the group position and builds one job per byte.
module b64se_front (
   input  logic              clock,
   input  logic              reset,
   b64se_req_if.sink         req,
   input  logic              full,
   output logic              push,
   output b64se_pkg::job_type job
);
   import b64se_pkg::*;

   grp_pos_type        grp_ff, grp_in;
   logic [CARRY_W-1:0] carry_ff, carry_in;
   logic [BYTE_W-1:0]  b;

   assign b         = req.data_byte;
   assign req.ready = !full;
   assign push      = req.valid && !full;

   always_comb begin
      job.chars    = {MAX_CHARS{PAD_CHAR}};
      job.msg_last = req.last_byte;
      unique case (grp_ff)
         GRP_SECOND: begin
            job.chars[0] = sextet_char({carry_ff[1:0], b[7:4]});
            job.chars[1] = sextet_char({b[3:0], 2'b00});
            job.last_idx = req.last_byte ? CIDX_W'(2) : CIDX_W'(0);
            grp_in       = GRP_THIRD;
            carry_in     = b[3:0];
         end
         GRP_THIRD: begin
            job.chars[0] = sextet_char({carry_ff, b[7:6]});
            job.chars[1] = sextet_char(b[5:0]);
            job.last_idx = CIDX_W'(1);
            grp_in       = GRP_FIRST;
            carry_in     = '0;
         end
         default: begin
            job.chars[0] = sextet_char(b[7:2]);
            job.chars[1] = sextet_char({b[1:0], 4'b0000});
            job.last_idx = req.last_byte ? CIDX_W'(3) : CIDX_W'(0);
            grp_in       = GRP_SECOND;
            carry_in     = {2'b00, b[1:0]};
         end
      endcase
      if (req.last_byte) begin
         grp_in   = GRP_FIRST;
         carry_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grp_ff   <= GRP_FIRST;
         carry_ff <= '0;
      end else if (push) begin
         grp_ff   <= grp_in;
         carry_ff <= carry_in;
      end
   end

   // a closing byte always leaves the encoder at the start of a fresh group
   a_last_restarts: assert property (@(posedge clock) disable iff (reset)
      (push && req.last_byte) |=> (grp_ff == GRP_FIRST && carry_ff == '0))
      else $error("group state not cleared after final byte");

endmodule

// ===== rtl/b64se_queue.sv =====
// Short job queue between the front and back ends.
module b64se_queue #(
   parameter int DEPTH = b64se_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  b64se_pkg::job_type push_job,
   input  logic               pop,
   output logic               full,
   output logic               head_valid,
   output b64se_pkg::job_type head_job
);
   import b64se_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type            mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push)
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      if (pop)
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      if (push && !pop)
         count_in = count_ff + 1'b1;
      else if (pop && !push)
         count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push)
         mem_ff[wr_ptr_ff] <= push_job;
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("job queue written while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && !head_valid))
      else $error("job queue read while empty");

endmodule

// ===== rtl/b64se_back.sv =====
// Back end: walks the head job one character a cycle into the output register, while that register is empty or taken.
module b64se_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               head_valid,
   input  b64se_pkg::job_type head_job,
   output logic               pop,
   b64se_rsp_if.source        rsp
);
   import b64se_pkg::*;

   logic [CIDX_W-1:0] idx_ff, idx_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0] char_ff;
   logic              run_last_ff, msg_end_ff;
   logic              advance, emit, at_end;

   assign advance = !rsp_valid_ff || rsp.ready;
   assign emit    = advance && head_valid;
   assign at_end  = (idx_ff == head_job.last_idx);
   assign pop     = emit && at_end;

   always_comb begin
      rsp_valid_in = advance ? head_valid : rsp_valid_ff;
      idx_in       = idx_ff;
      if (emit)
         idx_in = at_end ? '0 : idx_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         char_ff     <= head_job.chars[idx_ff];
         run_last_ff <= at_end;
         msg_end_ff  <= at_end && head_job.msg_last;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.char_code   = char_ff;
   assign rsp.run_last    = run_last_ff;
   assign rsp.message_end = msg_end_ff;

   // mid-job index only exists while that job still sits at the queue head
   a_idx_has_job: assert property (@(posedge clock) disable iff (reset)
      (idx_ff != '0) |-> head_valid)
      else $error("character index set with no job at queue head");
   a_end_is_run_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!msg_end_ff || run_last_ff))
      else $error("message end flagged on a non-final character");

endmodule
